/* hdl/assert_macros.svh */
// Assertion helpers for the block. Each use expands to one labeled concurrent assertion
// that is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LCPA_ASSERT_IMP(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`define LCPA_ASSERT_NXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/lcpa_pkg.sv */
package lcpa_pkg;

	localparam int SYM_W = 8;
	localparam int POS_W = 12;
	localparam int DATA_IN_W = 24;
	localparam int DATA_OUT_W = 24;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [POS_W-1:0] LCP_MAX = 12'hFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_INV,
		ST_RANK,
		ST_RWAIT,
		ST_SUFF,
		ST_CMP
	} state_t;

endpackage

/* hdl/lcp_array_from_suffix_array.sv */
// LCP array from a suffix array, computed with Kasai's method over block memories.
// Input stream s_*: tuser 0 is a load request carrying one text symbol and the start
// of the suffix at the next rank; tlast on a load marks the final symbol and starts
// the pass. tuser 1 is a read request that returns the next rank's prefix length.
// Output stream m_*: one result per read request, in rank order; tlast marks the
// highest rank, after which reads wrap to rank zero. Reads before a pass give nothing.
// Loads are taken one per cycle while the block is idle. After the final load it holds
// s_tready low for the pass: it inverts the suffix array into a rank table, then for
// each text position reads its rank and the previous rank's suffix start and compares
// symbols until a mismatch or the text end, keeping the match length less one.
// The text is kept in two copies so that both compared symbols are read at once;
// every memory has a single read port, and its read data is registered.
// A read request moves the block to ST_READ, which fills the output register that
// drives m_*; no request is taken in ST_READ, so a new read request waits until the
// block is back in ST_IDLE. The result sits in an output register; while the
// receiver stalls, loads are still taken but a further read request waits.
// Reset clears the control state; memory contents stay undefined until loaded.
// A load after a finished pass starts a new text.
`include "assert_macros.svh"

module lcp_array_from_suffix_array #(
	parameter int MAX_LEN = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lcpa_pkg::DATA_IN_W-1:0]  s_tdata,   // symbol[7:0], suffix_start[19:8], zero[23:20]
	input  logic                            s_tuser,   // cmd
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lcpa_pkg::DATA_OUT_W-1:0] m_tdata,   // rank_index[11:0], lcp_length[23:12]
	output logic                            m_tlast
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int JW = (LW > lcpa_pkg::POS_W) ? LW : lcpa_pkg::POS_W;
	localparam int SW = JW + 1;

	lcpa_pkg::state_t state_q, state_d;

	logic [LW-1:0] len_q, len_d;
	logic          done_q, done_d;
	logic [AW-1:0] rp_q, rp_d;
	logic [LW-1:0] idx_q, idx_d;
	logic [LW-1:0] p_q, p_d;
	logic [AW-1:0] rk_q, rk_d;
	logic [lcpa_pkg::POS_W-1:0] j_q, j_d;
	logic          v_s1, v_s1_d;
	logic [AW-1:0] r_s1, r_s1_d;
	logic          out_v_q, out_v_d;
	logic [lcpa_pkg::POS_W-1:0] out_rank_q, out_rank_d;
	logic [lcpa_pkg::POS_W-1:0] out_lcp_q, out_lcp_d;
	logic          out_fin_q, out_fin_d;

	logic                      tx_we;
	logic [AW-1:0]             tx_waddr;
	logic [AW-1:0]             txa_raddr, txb_raddr;
	logic [lcpa_pkg::SYM_W-1:0] txa_rdata, txb_rdata;
	logic                      suf_we;
	logic [AW-1:0]             suf_raddr;
	logic [lcpa_pkg::POS_W-1:0] suf_rdata;
	logic                      rank_we;
	logic [AW-1:0]             rank_waddr, rank_raddr, rank_rdata;
	logic                      lcp_we;
	logic [lcpa_pkg::POS_W-1:0] lcp_wdata, lcp_rdata;

	logic [LW-1:0] eff_len;
	logic [SW-1:0] lenx, ip, jp, jp_new, ip1, jp1;
	logic [JW-1:0] suf_x, rp_x;
	logic [LW-1:0] idx_inc, rp_inc, p_inc;
	logic          rk_ok, bnd_q, bnd_new, bnd_nxt, match;
	logic          finish, wr_lcp;
	logic [LW-1:0] fin_p;
	logic [JW-1:0] fin_w;

	assign eff_len = done_q ? '0 : len_q;
	assign lenx    = SW'(len_q);
	assign ip      = SW'(idx_q) + SW'(p_q);
	assign jp      = SW'(j_q) + SW'(p_q);
	assign jp_new  = SW'(suf_rdata) + SW'(p_q);
	assign ip1     = ip + SW'(1);
	assign jp1     = jp + SW'(1);
	assign suf_x   = JW'(suf_rdata);
	assign rp_x    = JW'(rp_q);
	assign idx_inc = idx_q + LW'(1);
	assign rp_inc  = LW'(rp_q) + LW'(1);
	assign p_inc   = p_q + LW'(1);
	assign rk_ok   = (rank_rdata != '0) && (LW'(rank_rdata) < len_q);
	assign bnd_new = (ip < lenx) && (jp_new < lenx);
	assign bnd_nxt = (ip1 < lenx) && (jp1 < lenx);
	assign bnd_q   = (ip < lenx) && (jp < lenx);
	assign match   = txa_rdata == txb_rdata;

	assign rank_we    = v_s1 && (SW'(suf_rdata) < lenx);
	assign rank_waddr = suf_x[AW-1:0];

	always_comb begin
		state_d    = state_q;
		len_d      = len_q;
		done_d     = done_q;
		rp_d       = rp_q;
		idx_d      = idx_q;
		p_d        = p_q;
		rk_d       = rk_q;
		j_d        = j_q;
		v_s1_d     = 1'b0;
		r_s1_d     = r_s1;
		out_v_d    = out_v_q && !m_tready;
		out_rank_d = out_rank_q;
		out_lcp_d  = out_lcp_q;
		out_fin_d  = out_fin_q;
		s_tready   = 1'b0;
		tx_we      = 1'b0;
		suf_we     = 1'b0;
		tx_waddr   = eff_len[AW-1:0];
		suf_raddr  = idx_q[AW-1:0];
		rank_raddr = idx_q[AW-1:0];
		txa_raddr  = ip[AW-1:0];
		txb_raddr  = jp[AW-1:0];
		finish     = 1'b0;
		wr_lcp     = 1'b0;
		fin_p      = p_q;
		case (state_q)
			lcpa_pkg::ST_IDLE: begin
				s_tready = (s_tuser == lcpa_pkg::CMD_LOAD) || !out_v_q || m_tready;
				if (s_tvalid && s_tready) begin
					if (s_tuser == lcpa_pkg::CMD_LOAD) begin
						if (done_q) begin
							done_d = 1'b0;
							rp_d   = '0;
						end
						len_d = eff_len;
						if (eff_len < LW'(MAX_LEN)) begin
							tx_we  = 1'b1;
							suf_we = 1'b1;
							len_d  = eff_len + LW'(1);
						end
						if (s_tlast) begin
							state_d = lcpa_pkg::ST_INV;
							idx_d   = '0;
						end
					end else if (done_q) begin
						state_d = lcpa_pkg::ST_READ;
					end
				end
			end
			lcpa_pkg::ST_READ: begin
				out_v_d    = 1'b1;
				out_rank_d = rp_x[lcpa_pkg::POS_W-1:0];
				out_lcp_d  = (rp_q == '0) ? '0 : lcp_rdata;
				out_fin_d  = rp_inc >= len_q;
				rp_d       = (rp_inc >= len_q) ? '0 : rp_inc[AW-1:0];
				state_d    = lcpa_pkg::ST_IDLE;
			end
			lcpa_pkg::ST_INV: begin
				if (idx_q != len_q) begin
					v_s1_d = 1'b1;
					r_s1_d = idx_q[AW-1:0];
					idx_d  = idx_inc;
				end else if (!v_s1) begin
					state_d = lcpa_pkg::ST_RANK;
					idx_d   = '0;
					p_d     = '0;
				end
			end
			lcpa_pkg::ST_RANK: begin
				state_d = lcpa_pkg::ST_RWAIT;
			end
			lcpa_pkg::ST_RWAIT: begin
				if (rk_ok) begin
					rk_d      = rank_rdata;
					suf_raddr = rank_rdata - AW'(1);
					state_d   = lcpa_pkg::ST_SUFF;
				end else begin
					finish = 1'b1;
				end
			end
			lcpa_pkg::ST_SUFF: begin
				j_d       = suf_rdata;
				txb_raddr = jp_new[AW-1:0];
				if (bnd_new) begin
					state_d = lcpa_pkg::ST_CMP;
				end else begin
					finish = 1'b1;
					wr_lcp = 1'b1;
				end
			end
			lcpa_pkg::ST_CMP: begin
				txa_raddr = ip1[AW-1:0];
				txb_raddr = jp1[AW-1:0];
				if (match && bnd_q) begin
					p_d = p_inc;
					if (!bnd_nxt) begin
						finish = 1'b1;
						wr_lcp = 1'b1;
						fin_p  = p_inc;
					end
				end else begin
					finish = 1'b1;
					wr_lcp = 1'b1;
				end
			end
			default: begin
				state_d = lcpa_pkg::ST_IDLE;
			end
		endcase
		if (finish) begin
			p_d   = (fin_p != '0) ? fin_p - LW'(1) : fin_p;
			idx_d = idx_inc;
			if (idx_inc == len_q) begin
				state_d = lcpa_pkg::ST_IDLE;
				done_d  = 1'b1;
				rp_d    = '0;
			end else begin
				state_d = lcpa_pkg::ST_RANK;
			end
		end
	end

	assign fin_w     = JW'(fin_p);
	assign lcp_we    = wr_lcp;
	assign lcp_wdata = (fin_w > JW'(lcpa_pkg::LCP_MAX)) ? lcpa_pkg::LCP_MAX
		: fin_w[lcpa_pkg::POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcpa_pkg::ST_IDLE;
			len_q   <= '0;
			done_q  <= 1'b0;
			rp_q    <= '0;
			idx_q   <= '0;
			p_q     <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			done_q  <= done_d;
			rp_q    <= rp_d;
			idx_q   <= idx_d;
			p_q     <= p_d;
			v_s1    <= v_s1_d;
			out_v_q <= out_v_d;
		end
	end

	always_ff @(posedge clk) begin
		rk_q       <= rk_d;
		j_q        <= j_d;
		r_s1       <= r_s1_d;
		out_rank_q <= out_rank_d;
		out_lcp_q  <= out_lcp_d;
		out_fin_q  <= out_fin_d;
	end

	lcpa_ram #(.DEPTH(MAX_LEN), .WIDTH(lcpa_pkg::SYM_W)) u_text_a (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (s_tdata[7:0]),
		.raddr (txa_raddr),
		.rdata (txa_rdata)
	);

	lcpa_ram #(.DEPTH(MAX_LEN), .WIDTH(lcpa_pkg::SYM_W)) u_text_b (
		.clk   (clk),
		.we    (tx_we),
		.waddr (tx_waddr),
		.wdata (s_tdata[7:0]),
		.raddr (txb_raddr),
		.rdata (txb_rdata)
	);

	lcpa_ram #(.DEPTH(MAX_LEN), .WIDTH(lcpa_pkg::POS_W)) u_suffix (
		.clk   (clk),
		.we    (suf_we),
		.waddr (tx_waddr),
		.wdata (s_tdata[19:8]),
		.raddr (suf_raddr),
		.rdata (suf_rdata)
	);

	lcpa_ram #(.DEPTH(MAX_LEN), .WIDTH(AW)) u_rank (
		.clk   (clk),
		.we    (rank_we),
		.waddr (rank_waddr),
		.wdata (r_s1),
		.raddr (rank_raddr),
		.rdata (rank_rdata)
	);

	lcpa_ram #(.DEPTH(MAX_LEN), .WIDTH(lcpa_pkg::POS_W)) u_lcp (
		.clk   (clk),
		.we    (lcp_we),
		.waddr (rk_q),
		.wdata (lcp_wdata),
		.raddr (rp_q),
		.rdata (lcp_rdata)
	);

	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_lcp_q, out_rank_q};
	assign m_tlast  = out_fin_q;

	`LCPA_ASSERT_IMP(a_match_len_bound, state_q != lcpa_pkg::ST_IDLE, p_q <= len_q, "bad match")
	`LCPA_ASSERT_IMP(a_read_slot_free, state_q == lcpa_pkg::ST_READ, !out_v_q, "output busy")
	`LCPA_ASSERT_IMP(a_read_ptr_range, done_q, LW'(rp_q) < len_q, "read pointer out of range")
	`LCPA_ASSERT_NXT(a_inv_stage, v_s1_d, state_q == lcpa_pkg::ST_INV, "stray rank write")

endmodule

/* hdl/lcpa_ram.sv */
module lcpa_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
